// ===== hw/rtl/prct_pkg.sv =====
`timescale 1ns / 1ps

package prct_pkg;

   localparam int MAX_LENGTH = 4096;
   localparam int ADDR_W     = $clog2(MAX_LENGTH);
   localparam int IDX_W      = 13;
   localparam int CNT_W      = 13;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_SWAP  = 2'd2;

   // permutation tables and descent flags
   typedef struct packed {
      logic     vap_we;
      addr_type vap_wa;
      idx_type  vap_wd;
      addr_type vap_ra0;
      addr_type vap_ra1;
      logic     pov_we;
      addr_type pov_wa;
      idx_type  pov_wd;
      addr_type pov_ra0;
      addr_type pov_ra1;
      logic     flag_we;
      addr_type flag_wa;
      logic     flag_wd;
      addr_type flag_ra;
   } perm_req_type;

   typedef struct packed {
      idx_type vap_rd0;
      idx_type vap_rd1;
      idx_type pov_rd0;
      idx_type pov_rd1;
      logic    flag_rd;
   } perm_rsp_type;

   typedef struct packed {
      logic     we;
      addr_type wa;
      cnt_type  wd;
      addr_type ra;
   } tree_req_type;

   function automatic logic [IDX_W:0] low_bit(input logic [IDX_W:0] x);
      return x & (~x + 1'b1);
   endfunction

endpackage

// ===== hw/rtl/permutation_run_count_tree_unit.sv =====
`timescale 1ns / 1ps
// load: writes both tables, then up to 2 flag refreshes; swap: SW_W1 and SW_W2, then up to 4 refreshes
// refresh: read in RF_NEXT, compare in RF_CMP, plus a tree path update when the flag flips
// query: walks the sum tree for the high bound, then for the low bound; one item at a time
// tree update and query timing set by the single read and write port of the sum tree memory
// synchronous reset; afterwards a clearing pass over all 4096 entries of position table,
// flags and sum tree during which req_stall stays high
module permutation_run_count_tree_unit
   import prct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [12:0] req_first,
   input  logic [12:0] req_second,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_run_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_perm_length
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SW_W1, ST_SW_W2, ST_RF_NEXT, ST_RF_CMP,
      ST_TREE, ST_Q_WALK, ST_Q_DONE
   } state_type;

   state_type    state_ff;
   idx_type      clr_ff;
   idx_type      len_ff;
   idx_type      a_ff, b_ff, y_ff;
   idx_type      rf_list_ff [4];
   logic [2:0]   rf_num_ff;
   logic [2:0]   rf_cnt_ff;
   idx_type      rf_idx_ff;
   idx_type      tw_idx_ff;
   logic         tw_up_ff;
   idx_type      qi_ff, q_lo_ff;
   logic         q_phase_ff, pend_ff, pend_sub_ff;
   cnt_type      sum_ff;
   logic         rsp_valid_ff;
   cnt_type      rsp_count_ff;

   perm_req_type perm_req;
   perm_rsp_type perm_rsp;
   tree_req_type tree_req;
   cnt_type      tree_rd;

   idx_type      n_len;
   logic         accept;
   logic         a_ok, b_ok, y_ok, z_ok;
   idx_type      q_lo, q_hi, rf_cur;
   logic         rf_ok, new_flag;
   logic [IDX_W:0] tw_next;
   logic         tw_more;
   idx_type      q_next;

   prct_perm_mem u_perm (.clock(clock), .req(perm_req), .rsp(perm_rsp));
   prct_tree_mem u_tree (.clock(clock), .req(tree_req), .rd_data(tree_rd));

   // effective length clamped to 1..max
   always_comb begin
      if (len_ff == '0) n_len = idx_type'(1);
      else if (len_ff > idx_type'(MAX_LENGTH)) n_len = idx_type'(MAX_LENGTH);
      else n_len = len_ff;
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign a_ok      = (req_first != '0) && (req_first <= n_len);
   assign b_ok      = (req_second != '0) && (req_second <= n_len);
   assign y_ok      = (perm_rsp.vap_rd0 != '0) && (perm_rsp.vap_rd0 <= n_len);
   assign z_ok      = (y_ff != '0) && (y_ff <= n_len);
   assign q_lo      = (req_first == '0) ? idx_type'(1) : req_first;
   assign q_hi      = (req_second > n_len) ? n_len : req_second;

   // flag index in 1..max-1 only
   assign rf_cur    = rf_list_ff[rf_cnt_ff[1:0]];
   assign rf_ok     = (rf_cur != '0) && (rf_cur < idx_type'(MAX_LENGTH));
   assign new_flag  = perm_rsp.pov_rd0 > perm_rsp.pov_rd1;

   assign tw_next   = {1'b0, tw_idx_ff} + low_bit({1'b0, tw_idx_ff});
   assign tw_more   = tw_next <= (IDX_W+1)'(MAX_LENGTH);
   assign q_next    = qi_ff - idx_type'(low_bit({1'b0, qi_ff}));

   // memory port steering
   always_comb begin
      perm_req = '0;
      tree_req = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            perm_req.pov_we  = 1'b1;
            perm_req.pov_wa  = clr_ff[ADDR_W-1:0];
            perm_req.flag_we = 1'b1;
            perm_req.flag_wa = clr_ff[ADDR_W-1:0];
            tree_req.we      = 1'b1;
            tree_req.wa      = clr_ff[ADDR_W-1:0];
         end
         ST_IDLE: begin
            perm_req.vap_ra0 = ADDR_W'(req_first - 1'b1);
            perm_req.vap_ra1 = ADDR_W'(req_second - 1'b1);
            if (accept && req_func == FUNC_LOAD && a_ok && b_ok) begin
               perm_req.vap_we = 1'b1;
               perm_req.vap_wa = ADDR_W'(req_first - 1'b1);
               perm_req.vap_wd = req_second;
               perm_req.pov_we = 1'b1;
               perm_req.pov_wa = ADDR_W'(req_second - 1'b1);
               perm_req.pov_wd = req_first;
            end
         end
         ST_SW_W1: begin
            perm_req.vap_we = 1'b1;
            perm_req.vap_wa = ADDR_W'(a_ff - 1'b1);
            perm_req.vap_wd = perm_rsp.vap_rd1;
            perm_req.pov_we = y_ok;
            perm_req.pov_wa = ADDR_W'(perm_rsp.vap_rd0 - 1'b1);
            perm_req.pov_wd = b_ff;
         end
         ST_SW_W2: begin
            // y_ff holds z here, the second value, moved to the first position
            perm_req.vap_we = 1'b1;
            perm_req.vap_wa = ADDR_W'(b_ff - 1'b1);
            perm_req.vap_wd = rf_list_ff[1];
            perm_req.pov_we = z_ok;
            perm_req.pov_wa = ADDR_W'(y_ff - 1'b1);
            perm_req.pov_wd = a_ff;
         end
         ST_RF_NEXT: begin
            perm_req.pov_ra0 = ADDR_W'(rf_cur - 1'b1);
            perm_req.pov_ra1 = ADDR_W'(rf_cur);
            perm_req.flag_ra = ADDR_W'(rf_cur);
         end
         ST_RF_CMP: begin
            perm_req.flag_we = (new_flag != perm_rsp.flag_rd);
            perm_req.flag_wa = ADDR_W'(rf_idx_ff);
            perm_req.flag_wd = new_flag;
            tree_req.ra      = ADDR_W'(rf_idx_ff - 1'b1);
         end
         ST_TREE: begin
            tree_req.we = 1'b1;
            tree_req.wa = ADDR_W'(tw_idx_ff - 1'b1);
            tree_req.wd = tw_up_ff ? tree_rd + 1'b1 : tree_rd - 1'b1;
            tree_req.ra = ADDR_W'(tw_next - 1'b1);
         end
         ST_Q_WALK: begin
            tree_req.ra = ADDR_W'(qi_ff - 1'b1);
         end
         ST_Q_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         len_ff       <= idx_type'(MAX_LENGTH);
         rsp_valid_ff <= 1'b0;
         rf_num_ff    <= '0;
         rf_cnt_ff    <= '0;
         pend_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) len_ff <= csr_perm_length;
         // the completion step handles the result register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_Q_DONE) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == idx_type'(MAX_LENGTH - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               a_ff      <= req_first;
               b_ff      <= req_second;
               rf_cnt_ff <= '0;
               if (accept) begin
                  unique case (req_func)
                     FUNC_LOAD: begin
                        if (a_ok && b_ok) begin
                           rf_list_ff[0] <= req_second - 1'b1;
                           rf_list_ff[1] <= req_second;
                           rf_num_ff     <= 3'd2;
                           state_ff      <= ST_RF_NEXT;
                        end
                     end
                     FUNC_QUERY: begin
                        qi_ff      <= q_hi - 1'b1;
                        q_lo_ff    <= q_lo - 1'b1;
                        q_phase_ff <= 1'b0;
                        pend_ff    <= 1'b0;
                        if (req_first > req_second || q_lo > q_hi) begin
                           sum_ff   <= '0;
                           state_ff <= ST_Q_DONE;
                        end else begin
                           sum_ff   <= cnt_type'(1);
                           state_ff <= ST_Q_WALK;
                        end
                     end
                     FUNC_SWAP: begin
                        if (a_ok && b_ok) state_ff <= ST_SW_W1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SW_W1: begin
               // list holds y-1, y, z-1, z
               rf_list_ff[0] <= perm_rsp.vap_rd0 - 1'b1;
               rf_list_ff[1] <= perm_rsp.vap_rd0;
               rf_list_ff[2] <= perm_rsp.vap_rd1 - 1'b1;
               rf_list_ff[3] <= perm_rsp.vap_rd1;
               rf_num_ff     <= 3'd4;
               y_ff          <= perm_rsp.vap_rd1;
               state_ff      <= ST_SW_W2;
            end
            ST_SW_W2: begin
               state_ff <= ST_RF_NEXT;
            end
            ST_RF_NEXT: begin
               rf_idx_ff <= rf_cur;
               if (rf_cnt_ff == rf_num_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  rf_cnt_ff <= rf_cnt_ff + 1'b1;
                  if (rf_ok) state_ff <= ST_RF_CMP;
               end
            end
            ST_RF_CMP: begin
               tw_idx_ff <= rf_idx_ff;
               tw_up_ff  <= new_flag;
               state_ff  <= (new_flag != perm_rsp.flag_rd) ? ST_TREE : ST_RF_NEXT;
            end
            ST_TREE: begin
               tw_idx_ff <= idx_type'(tw_next);
               if (!tw_more) state_ff <= ST_RF_NEXT;
            end
            ST_Q_WALK: begin
               if (pend_ff) sum_ff <= pend_sub_ff ? sum_ff - tree_rd : sum_ff + tree_rd;
               pend_sub_ff <= q_phase_ff;
               if (qi_ff != '0) begin
                  pend_ff <= 1'b1;
                  qi_ff   <= q_next;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     if (!q_phase_ff) begin
                        q_phase_ff <= 1'b1;
                        qi_ff      <= q_lo_ff;
                     end else begin
                        state_ff <= ST_Q_DONE;
                     end
                  end
               end
            end
            ST_Q_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= sum_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_count = rsp_count_ff;

   // tree walk never reads the node it writes back in the same cycle, before its last step
   a_tree_rw_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TREE && tw_more) |-> (tree_req.ra != tree_req.wa))
      else $error("tree read and write collide");

   // a result only appears out of the query completion step
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_Q_DONE))
      else $error("result without query");

   // refresh pointer stays inside its list
   a_rf_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RF_NEXT) |-> (rf_cnt_ff <= rf_num_ff))
      else $error("refresh pointer overrun");

endmodule

// ===== hw/rtl/prct_perm_mem.sv =====
`timescale 1ns / 1ps

module prct_perm_mem (
   input  logic                  clock,
   input  prct_pkg::perm_req_type req,
   output prct_pkg::perm_rsp_type rsp
);
   import prct_pkg::*;

   idx_type      vap_mem  [MAX_LENGTH];
   idx_type      pov_mem  [MAX_LENGTH];
   logic         flag_mem [MAX_LENGTH];
   perm_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (req.vap_we) vap_mem[req.vap_wa] <= req.vap_wd;
      if (req.pov_we) pov_mem[req.pov_wa] <= req.pov_wd;
      if (req.flag_we) flag_mem[req.flag_wa] <= req.flag_wd;
      rsp_ff.vap_rd0 <= vap_mem[req.vap_ra0];
      rsp_ff.vap_rd1 <= vap_mem[req.vap_ra1];
      rsp_ff.pov_rd0 <= pov_mem[req.pov_ra0];
      rsp_ff.pov_rd1 <= pov_mem[req.pov_ra1];
      rsp_ff.flag_rd <= flag_mem[req.flag_ra];
   end

   assign rsp = rsp_ff;

endmodule

// ===== hw/rtl/prct_tree_mem.sv =====
`timescale 1ns / 1ps

module prct_tree_mem (
   input  logic                  clock,
   input  prct_pkg::tree_req_type req,
   output prct_pkg::cnt_type      rd_data
);
   import prct_pkg::*;

   cnt_type tree_mem [MAX_LENGTH];
   cnt_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) tree_mem[req.wa] <= req.wd;
      rd_data_ff <= tree_mem[req.ra];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/run_count_checker.sv =====
`timescale 1ns / 1ps

module run_count_checker
   import prct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [12:0] req_first,
   input  logic [12:0] req_second,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [12:0] rsp_run_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [12:0] csr_perm_length,
   output int          fail_count,
   output int          pending_count
);

   logic [12:0] length_reg;
   logic [12:0] value_at [0:MAX_LENGTH];
   logic [12:0] pos_of [0:MAX_LENGTH];
   logic        descent [0:MAX_LENGTH];
   cnt_type     expected_counts [$];

   function automatic int active_length();
      if (length_reg < 1) return 1;
      if (length_reg > MAX_LENGTH) return MAX_LENGTH;
      return length_reg;
   endfunction

   function automatic void refresh(int i);
      if (i < 1 || i >= MAX_LENGTH) return;
      descent[i] = pos_of[i] > pos_of[i+1];
   endfunction

   // flags summed directly, same result as the tree
   function automatic cnt_type count_runs(int lo, int hi, int n);
      int s;
      s = 0;
      if (lo > hi) return '0;
      if (lo < 1) lo = 1;
      if (hi > n) hi = n;
      if (lo > hi) return '0;
      for (int i = lo; i < hi; i++) s += descent[i];
      s += 1;
      if (s > 8191) s = 8191;
      return cnt_type'(s);
   endfunction

   task automatic apply_item(logic [1:0] f, int a, int b);
      int n, y, z;
      n = active_length();
      case (f)
         FUNC_LOAD: begin
            if (a >= 1 && a <= n && b >= 1 && b <= n) begin
               value_at[a] = 13'(b);
               pos_of[b] = 13'(a);
               refresh(b - 1);
               refresh(b);
            end
         end
         FUNC_QUERY: expected_counts.push_back(count_runs(a, b, n));
         FUNC_SWAP: begin
            if (a >= 1 && a <= n && b >= 1 && b <= n) begin
               y = value_at[a];
               z = value_at[b];
               value_at[a] = 13'(z);
               value_at[b] = 13'(y);
               if (y >= 1 && y <= n) pos_of[y] = 13'(b);
               if (z >= 1 && z <= n) pos_of[z] = 13'(a);
               refresh(y - 1);
               refresh(y);
               refresh(z - 1);
               refresh(z);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      cnt_type want;
      if (reset) begin
         length_reg <= 13'd4096;
         for (int i = 0; i <= MAX_LENGTH; i++) begin
            value_at[i] = '0;
            pos_of[i] = '0;
            descent[i] = 1'b0;
         end
         expected_counts.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) length_reg <= csr_perm_length;
         if (req_valid && !req_stall) apply_item(req_func, req_first, req_second);
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result transfer: run_count %0d", rsp_run_count);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_counts.pop_front();
               if (rsp_run_count !== want) begin
                  if (fail_count < 10)
                     $display("run_count mismatch: expected %0d actual %0d",
                              want, rsp_run_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = expected_counts.size();

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import prct_pkg::*;

   localparam logic [1:0] FUNC_NOP = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_NOP;
   logic [12:0] req_first = '0;
   logic [12:0] req_second = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [12:0] rsp_run_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_perm_length = '0;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   bit          hold_off = 1'b0;
   int          cur_length = 4096;
   int          loaded_upto = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   permutation_run_count_tree_unit u_top (.*);

   run_count_checker u_check (.*);

   // short gaps mostly, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // receiver: random stall, long hold-off when requested
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 3) == 0) || ($urandom_range(0, 40) == 0);
   end

   // watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // with no gap, valid stays high into the next transfer
   task automatic send_item(logic [1:0] f, logic [12:0] a, logic [12:0] b);
      int g;
      req_valid <= 1'b1;
      req_func <= f;
      req_first <= a;
      req_second <= b;
      do @(posedge clock); while (req_stall);
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // wait for all results, then for the block to finish trailing flag work
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_length(int len);
      drain();
      csr_valid <= 1'b1;
      csr_perm_length <= 13'(len);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      cur_length = len;
      loaded_upto = 0;
   endtask

   // identity load, all positions written
   task automatic load_identity();
      for (int i = 1; i <= cur_length; i++) send_item(FUNC_LOAD, 13'(i), 13'(i));
      loaded_upto = cur_length;
   endtask

   // swaps only touch positions that hold a loaded value
   task automatic random_items(int count);
      int n, m, r, a, b, sa, sb;
      n = cur_length;
      m = (loaded_upto < n) ? loaded_upto : n;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         a = $urandom_range(1, n);
         b = $urandom_range(1, n);
         sa = (m > 0) ? $urandom_range(1, m) : 0;
         sb = (m > 0) ? $urandom_range(1, m) : 0;
         if (r < 35) send_item(FUNC_SWAP, 13'(sa), 13'(sb));
         else if (r < 75) begin
            if (a > b) begin int t; t = a; a = b; b = t; end
            send_item(FUNC_QUERY, 13'(a), 13'(b));
         end else if (r < 82) send_item(FUNC_QUERY, 13'(b), 13'(a));
         else if (r < 88) send_item(FUNC_LOAD, 13'($urandom), 13'($urandom));
         else if (r < 92) send_item(FUNC_SWAP, 13'($urandom_range(n + 1, 8191)), 13'(sb));
         else if (r < 96) send_item(FUNC_QUERY, 13'($urandom), 13'($urandom));
         else send_item(FUNC_NOP, 13'($urandom), 13'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full-size queries over the cleared tables, queries, loads and swaps at the extremes of the bounds
      send_item(FUNC_QUERY, 13'd1, 13'd4096);
      send_item(FUNC_QUERY, 13'd0, 13'd8191);
      send_item(FUNC_QUERY, 13'd4096, 13'd1);
      send_item(FUNC_QUERY, 13'd8191, 13'd8191);
      send_item(FUNC_NOP, 13'h1fff, 13'h1fff);
      send_item(FUNC_LOAD, 13'd4096, 13'd1);
      send_item(FUNC_LOAD, 13'd1, 13'd4096);
      send_item(FUNC_LOAD, 13'd0, 13'd5);
      send_item(FUNC_LOAD, 13'd8191, 13'd4097);
      send_item(FUNC_SWAP, 13'd1, 13'd4096);
      send_item(FUNC_SWAP, 13'd4097, 13'd1);
      send_item(FUNC_QUERY, 13'd1, 13'd4096);
      send_item(FUNC_QUERY, 13'd4095, 13'd4096);

      // small length, reversed permutation gives one run per value
      write_length(8);
      for (int i = 1; i <= 8; i++) send_item(FUNC_LOAD, 13'(i), 13'(9 - i));
      loaded_upto = 8;
      send_item(FUNC_QUERY, 13'd1, 13'd8);
      send_item(FUNC_QUERY, 13'd3, 13'd3);
      send_item(FUNC_QUERY, 13'd0, 13'd20);
      send_item(FUNC_LOAD, 13'd9, 13'd1);
      send_item(FUNC_SWAP, 13'd2, 13'd2);
      random_items(300);

      // pressure: receiver holds off while the sender keeps going
      hold_off = 1'b1;
      fork
         begin repeat (400) @(posedge clock); hold_off = 1'b0; end
         begin random_items(40); req_valid <= 1'b0; end
      join

      write_length(1);
      send_item(FUNC_LOAD, 13'd1, 13'd1);
      loaded_upto = 1;
      random_items(60);

      write_length(0);
      send_item(FUNC_LOAD, 13'd1, 13'd1);
      loaded_upto = 1;
      random_items(40);

      write_length(37);
      load_identity();
      random_items(500);

      write_length(3);
      load_identity();
      random_items(300);

      // positions 1..37 still hold values from the earlier identity load
      write_length(8191);
      loaded_upto = 37;
      random_items(80);

      write_length(200);
      load_identity();
      random_items(400);

      drain();
      if (fail_count == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule
